@@ rtl/raq_pkg.sv @@
// ----------------------------------------------------------------------------
// raq_pkg
// shared types, constants and helpers of the row absmax int8 quantizer
// ----------------------------------------------------------------------------
package raq_pkg;

  localparam int ROW_MAX   = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int RAM_DEPTH = 128;
  localparam int RAM_AW    = 7;
  localparam int DIV_W     = 57;
  localparam int MANT_W    = 24;

  localparam logic [31:0] SCALE_FLOOR = 32'h322B_CC77;
  localparam logic [31:0] FP_INF      = 32'h7F80_0000;
  localparam logic [DIV_W-1:0] RECIP_DVD = DIV_W'(1) << 49;

  localparam logic [3:0] QB_MIN   = 4'd2;
  localparam logic [3:0] QB_MAX   = 4'd8;
  localparam logic [3:0] QB_RESET = 4'd8;

  localparam logic [1:0] KIND_ZERO = 2'd0;
  localparam logic [1:0] KIND_SAT  = 2'd1;
  localparam logic [1:0] KIND_NUM  = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [30:0]      amax;
    logic             ovf;
    logic             bank;
  } row_desc_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [31:0]       data;
  } ram_wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [MANT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic             rem_nz;
  } div_rsp_t;

  function automatic logic [6:0] qmax_of(input logic [3:0] qb);
    logic [3:0] b;
    b = qb;
    if (qb < QB_MIN) b = QB_MIN;
    if (qb > QB_MAX) b = QB_MAX;
    return 7'((8'd1 << (b - 4'd1)) - 8'd1);
  endfunction

endpackage

@@ rtl/raq_ram.sv @@
// ----------------------------------------------------------------------------
// raq_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module raq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/raq_front.sv @@
// ----------------------------------------------------------------------------
// raq_front
// accepts row elements, stores them into a free bank and tracks the row max
// ----------------------------------------------------------------------------
module raq_front import raq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [31:0] in_value,
  input  logic      in_end,
  input  bank_rel_t rel,
  output ram_wr_t   wr,
  output logic      push,
  output row_desc_t desc,
  output logic [1:0] busy
);

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [30:0]      amax;
  logic [30:0]      amax_next;
  logic             ovf;
  logic             ovf_next;
  logic             wbank;
  logic [1:0]       busy_next;
  logic             accept;
  logic             store;
  logic [30:0]      mag;
  logic             mag_nan;

  assign in_ready = !busy[wbank];
  assign accept   = in_valid && in_ready;
  assign store    = fill < CNT_W'(ROW_MAX);
  assign mag      = in_value[30:0];
  assign mag_nan  = (&mag[30:23]) && (|mag[22:0]);

  always_comb begin
    fill_next = store ? fill + CNT_W'(1) : fill;
    amax_next = (store && !mag_nan && (mag > amax)) ? mag : amax;
    ovf_next  = ovf || !store;
  end

  assign wr.en   = accept && store;
  assign wr.addr = {wbank, fill[IDX_W-1:0]};
  assign wr.data = in_value;

  assign push       = accept && in_end;
  assign desc.count = fill_next;
  assign desc.amax  = amax_next;
  assign desc.ovf   = ovf_next;
  assign desc.bank  = wbank;

  always_comb begin
    busy_next = busy;
    if (rel.valid) busy_next[rel.bank] = 1'b0;
    if (push) busy_next[wbank] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      amax  <= '0;
      ovf   <= 1'b0;
      wbank <= 1'b0;
      busy  <= '0;
    end else begin
      busy <= busy_next;
      if (accept) begin
        if (in_end) begin
          fill  <= '0;
          amax  <= '0;
          ovf   <= 1'b0;
          wbank <= ~wbank;
        end else begin
          fill <= fill_next;
          amax <= amax_next;
          ovf  <= ovf_next;
        end
      end
    end
  end

endmodule

@@ rtl/raq_queue.sv @@
// ----------------------------------------------------------------------------
// raq_queue
// two-entry queue of closed row descriptors between front and back
// ----------------------------------------------------------------------------
module raq_queue import raq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  row_desc_t din,
  input  logic      pop,
  output row_desc_t dout,
  output logic      not_empty,
  output logic      full
);

  row_desc_t  entry [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign dout      = entry[rp];
  assign not_empty = cnt != 2'd0;
  assign full      = cnt == 2'd2;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

@@ rtl/raq_div.sv @@
// ----------------------------------------------------------------------------
// raq_div
// restoring divider, one quotient bit per cycle, shared by scale and reciprocal
// ----------------------------------------------------------------------------
module raq_div import raq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [5:0]        cnt;
  logic [MANT_W-1:0] rem;
  logic [MANT_W-1:0] dsr;
  logic [DIV_W-1:0]  dvd;
  logic [MANT_W:0]   part;
  logic              ge;
  logic [MANT_W:0]   diff;

  assign part = {rem, dvd[DIV_W-1]};
  assign ge   = part >= {1'b0, dsr};
  assign diff = part - {1'b0, dsr};

  assign rsp.done   = done;
  assign rsp.quot   = dvd;
  assign rsp.rem_nz = |rem;

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DIV_W-2:0], ge};
      rem <= ge ? diff[MANT_W-1:0] : part[MANT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/raq_back.sv @@
// ----------------------------------------------------------------------------
// raq_back
// per-row scale and reciprocal, then element read-out, quantize and output
// ----------------------------------------------------------------------------
module raq_back import raq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [3:0]        quant_bits,
  input  logic              q_valid,
  input  row_desc_t         q_desc,
  output logic              q_pop,
  output div_req_t          div_req,
  input  div_rsp_t          div_rsp,
  output logic              rd_en,
  output logic [RAM_AW-1:0] rd_addr,
  input  logic [31:0]       rd_data,
  output bank_rel_t         rel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_q,
  output logic [31:0]       out_scale,
  output logic              out_last,
  output logic              out_ovf
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SCL   = 3'd2;
  localparam logic [2:0] ST_RCP   = 3'd3;
  localparam logic [2:0] ST_INV   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;
  localparam logic [2:0] ST_DRAIN = 3'd6;

  logic [2:0]        state;
  row_desc_t         cur;
  logic [31:0]       scale;
  logic              inv_zero;
  logic [MANT_W-1:0] mi;
  logic signed [9:0] ei;
  logic [CNT_W-1:0]  idx;
  logic              adv;
  logic              issue;
  logic              issue_last;

  logic              s1_v;
  logic              s1_last;
  logic              s2_v;
  logic [47:0]       s2_prod;
  logic signed [9:0] s2_s;
  logic              s2_sign;
  logic [1:0]        s2_kind;
  logic              s2_last;

  // scale rounding
  logic [55:0] sq;
  logic [2:0]  sd;
  logic        sfound;
  logic [55:0] sqn;
  logic [23:0] smant;
  logic        sg;
  logic        sst;
  logic [24:0] sr;
  logic [8:0]  se;
  logic [31:0] scl_bits;

  // reciprocal rounding
  logic [26:0]       rq;
  logic              rhi;
  logic signed [9:0] rb;
  logic              rnorm;
  logic              rsh4;
  logic [23:0]       rmant;
  logic              rg;
  logic              rst_bit;
  logic [24:0]       rr;
  logic [MANT_W-1:0] inv_m;
  logic signed [9:0] inv_e;

  // element rounding
  logic              phi;
  logic signed [9:0] pt;
  logic [23:0]       pmant;
  logic              pg;
  logic              pst;
  logic [24:0]       pr;
  logic [4:0]        pk;
  logic [25:0]       psum;
  logic [25:0]       pq;
  logic [9:0]        qmag;
  logic [7:0]        num_q;
  logic [7:0]        sat_q;
  logic [7:0]        res_q;

  assign adv        = !out_valid || out_ready;
  assign issue      = (state == ST_EMIT) && adv;
  assign issue_last = idx == (cur.count - CNT_W'(1));
  assign rd_en      = issue;
  assign rd_addr    = {cur.bank, idx[IDX_W-1:0]};
  assign rel.valid  = issue && issue_last;
  assign rel.bank   = cur.bank;
  assign q_pop      = (state == ST_IDLE) && q_valid;

  always_comb begin
    sq     = div_rsp.quot[55:0];
    sd     = 3'd7;
    sfound = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!sfound && sq[55-i]) begin
        sd     = 3'(i);
        sfound = 1'b1;
      end
    end
    sqn      = sq << sd;
    smant    = sqn[55:32];
    sg       = sqn[31];
    sst      = (|sqn[30:0]) || div_rsp.rem_nz;
    sr       = {1'b0, smant} + 25'(sg && (sst || smant[0]));
    se       = {1'b0, cur.amax[30:23]} - {6'd0, sd} + {8'd0, sr[24]};
    scl_bits = {1'b0, se[7:0], sr[24] ? 23'd0 : sr[22:0]};
  end

  always_comb begin
    rq    = div_rsp.quot[26:0];
    rhi   = rq[26];
    rb    = (rhi ? 10'sd254 : 10'sd253) - $signed({2'b00, scale[30:23]});
    rnorm = rb > 10'sd0;
    rsh4  = scale[30:23] == 8'd254;
    if (rnorm && !rhi) begin
      rmant   = rq[25:2];
      rg      = rq[1];
      rst_bit = rq[0] || div_rsp.rem_nz;
    end else if (!rnorm && rsh4) begin
      rmant   = {1'b0, rq[26:4]};
      rg      = rq[3];
      rst_bit = (|rq[2:0]) || div_rsp.rem_nz;
    end else begin
      rmant   = rq[26:3];
      rg      = rq[2];
      rst_bit = (|rq[1:0]) || div_rsp.rem_nz;
    end
    rr = {1'b0, rmant} + 25'(rg && (rst_bit || rmant[0]));
    if (rnorm) begin
      if (rr[24]) begin
        inv_m = rr[24:1];
        inv_e = rb - 10'sd149;
      end else begin
        inv_m = rr[23:0];
        inv_e = rb - 10'sd150;
      end
    end else if (rr[23]) begin
      inv_m = rr[23:0];
      inv_e = -10'sd149;
    end else if (rr[22]) begin
      inv_m = {rr[22:0], 1'b0};
      inv_e = -10'sd150;
    end else begin
      inv_m = {rr[21:0], 2'b00};
      inv_e = -10'sd151;
    end
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = RECIP_DVD;
    div_req.divisor  = {1'b1, SCALE_FLOOR[22:0]};
    case (state)
      ST_IDLE: begin
        if (q_valid && (q_desc.amax > SCALE_FLOOR[30:0])) begin
          div_req.start    = q_desc.amax[30:23] != 8'hFF;
          div_req.dividend = {1'b0, 1'b1, q_desc.amax[22:0], 32'd0};
          div_req.divisor  = {17'd0, qmax_of(quant_bits)};
        end else begin
          div_req.start = q_valid;
        end
      end
      ST_SCL: begin
        div_req.start   = 1'b1;
        div_req.divisor = {1'b1, scl_bits[22:0]};
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          idx <= '0;
          if (q_valid) begin
            cur <= q_desc;
            if (q_desc.amax > SCALE_FLOOR[30:0]) begin
              if (q_desc.amax[30:23] == 8'hFF) begin
                scale    <= FP_INF;
                inv_zero <= 1'b1;
                state    <= ST_EMIT;
              end else begin
                inv_zero <= 1'b0;
                state    <= ST_DIV;
              end
            end else begin
              scale    <= SCALE_FLOOR;
              inv_zero <= 1'b0;
              state    <= ST_RCP;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) state <= ST_SCL;
        end
        ST_SCL: begin
          scale <= scl_bits;
          state <= ST_RCP;
        end
        ST_RCP: begin
          if (div_rsp.done) state <= ST_INV;
        end
        ST_INV: begin
          mi    <= inv_m;
          ei    <= inv_e;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (issue) begin
            idx <= idx + CNT_W'(1);
            if (issue_last) state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1_v && !s2_v) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // element pipeline: read, multiply, round into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v      <= issue;
      s2_v      <= s1_v;
      out_valid <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last  <= issue_last;
      s2_last  <= s1_last;
      s2_prod  <= {1'b1, rd_data[22:0]} * mi;
      s2_s     <= $signed({2'b00, rd_data[30:23]}) - 10'sd150 + ei;
      s2_sign  <= rd_data[31];
      if (rd_data[30:23] == 8'd0) begin
        s2_kind <= KIND_ZERO;
      end else if (rd_data[30:23] == 8'hFF) begin
        s2_kind <= ((|rd_data[22:0]) || inv_zero) ? KIND_ZERO : KIND_SAT;
      end else begin
        s2_kind <= inv_zero ? KIND_ZERO : KIND_NUM;
      end
      out_q     <= res_q;
      out_scale <= scale;
      out_last  <= s2_last;
      out_ovf   <= cur.ovf;
    end
  end

  always_comb begin
    phi   = s2_prod[47];
    pt    = s2_s + (phi ? 10'sd47 : 10'sd46);
    pmant = phi ? s2_prod[47:24] : s2_prod[46:23];
    pg    = phi ? s2_prod[23] : s2_prod[22];
    pst   = phi ? (|s2_prod[22:0]) : (|s2_prod[21:0]);
    pr    = {1'b0, pmant} + 25'(pg && (pst || pmant[0]));
    pk    = 5'(10'sd23 - pt);
    psum  = {1'b0, pr} + (26'd1 << (pk - 5'd1));
    pq    = psum >> pk;
    qmag  = pq[9:0];
    sat_q = s2_sign ? 8'h80 : 8'h7F;
    if (s2_sign) begin
      num_q = (qmag >= 10'd128) ? 8'h80 : (~qmag[7:0] + 8'd1);
    end else begin
      num_q = (qmag > 10'd127) ? 8'h7F : qmag[7:0];
    end
    case (s2_kind)
      KIND_SAT: res_q = sat_q;
      KIND_NUM: begin
        if (pt > 10'sd7) res_q = sat_q;
        else if (pt < -10'sd2) res_q = 8'd0;
        else res_q = num_q;
      end
      default: res_q = 8'd0;
    endcase
  end

endmodule

@@ rtl/row_absmax_int8_quantizer.sv @@
// ----------------------------------------------------------------------------
// row_absmax_int8_quantizer
// per-row symmetric int8 quantizer of fp32 elements with one fp32 scale per row
// after the row-end transaction the first valid result waits for two serial
// divisions in the shared divider (scale, then reciprocal), for the reciprocal
// division alone when the scale is the floor, and for none when it is infinite
// throughput: one element per cycle in and out when not stalled, plus the
// per-row scale and reciprocal time; two row banks let input and output overlap
// reset: control cleared, quant_bits set to 8, row storage contents kept
// ----------------------------------------------------------------------------
module row_absmax_int8_quantizer import raq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,   // quant_bits
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // value_bits
  input  logic        s_axis_tlast,  // row_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // q_value[7:0], scale_bits[39:8]
  output logic        m_axis_tlast,  // last_of_row
  output logic        m_axis_tuser   // row_overflow
);

  logic [3:0]  quant_bits;
  ram_wr_t     wr;
  bank_rel_t   rel;
  logic        q_push;
  row_desc_t   q_din;
  row_desc_t   q_dout;
  logic        q_pop;
  logic        q_not_empty;
  logic        q_full;
  logic [1:0]  bank_busy;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic        rd_en;
  logic [RAM_AW-1:0] rd_addr;
  logic [31:0] rd_data;
  logic [7:0]  out_q;
  logic [31:0] out_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      quant_bits <= QB_RESET;
    end else if (cfg_wr_en) begin
      quant_bits <= cfg_wr_data;
    end
  end

  raq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_value (s_axis_tdata),
    .in_end   (s_axis_tlast),
    .rel      (rel),
    .wr       (wr),
    .push     (q_push),
    .desc     (q_din),
    .busy     (bank_busy)
  );

  raq_ram #(
    .WIDTH (32),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  raq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .din       (q_din),
    .pop       (q_pop),
    .dout      (q_dout),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  raq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  raq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .quant_bits (quant_bits),
    .q_valid    (q_not_empty),
    .q_desc     (q_dout),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .rel        (rel),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_q      (out_q),
    .out_scale  (out_scale),
    .out_last   (m_axis_tlast),
    .out_ovf    (m_axis_tuser)
  );

  assign m_axis_tdata = {out_scale, out_q};

  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("row queue pushed while full");

  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_not_empty)
    else $error("row queue popped while empty");

  assert property (@(posedge clk) disable iff (rst) rel.valid |-> bank_busy[rel.bank])
    else $error("released a bank that was not owned");

endmodule
